>>> sv/wmf_pkg.sv
`timescale 1ns / 1ps

package wmf_pkg;

    localparam int MAX_HALF    = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int HALF_W      = 3;
    localparam int HIST_DEPTH  = 2 * MAX_HALF + 1;
    localparam int IDX_W       = $clog2(HIST_DEPTH);
    localparam int CNT_W       = $clog2(HIST_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [HALF_W-1:0]             half_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              cnt_t;

    typedef struct packed {
        logic shift_en;
        logic rank_clr;
        logic rank_en;
    } cell_ctrl_t;

    typedef struct packed {
        idx_t lo;
        idx_t hi;
    } win_t;

    // Window of samples lo..hi around the sample d places back, cut short at
    // the newest sample (index 0) and at the oldest sample held (lim).
    function automatic win_t win_bounds(input idx_t d, input idx_t h, input idx_t lim);
        win_t w;
        idx_t sum;
        w.lo = (d >= h) ? idx_t'(d - h) : '0;
        sum  = idx_t'(d + h);
        w.hi = (sum > lim) ? lim : sum;
        return w;
    endfunction

endpackage

>>> sv/wmf_stream_if.sv
`timescale 1ns / 1ps

interface wmf_in_if;
    logic             valid;
    logic             ready;
    wmf_pkg::sample_t sample;
    logic             end_of_seq;

    modport source (output valid, output sample, output end_of_seq, input ready);
    modport sink   (input valid, input sample, input end_of_seq, output ready);
endinterface

interface wmf_out_if;
    logic             valid;
    logic             ready;
    wmf_pkg::sample_t median;
    logic             last;

    modport source (output valid, output median, output last, input ready);
    modport sink   (input valid, input median, input last, output ready);
endinterface

>>> sv/wmf_cell.sv
`timescale 1ns / 1ps

module wmf_cell (
    input  logic                clk,
    input  wmf_pkg::cell_ctrl_t ctrl,
    input  wmf_pkg::sample_t    shift_in,
    input  wmf_pkg::sample_t    probe,
    input  logic                probe_before,
    output wmf_pkg::sample_t    held,
    output wmf_pkg::idx_t       rank
);
    import wmf_pkg::*;

    sample_t sample_reg;
    idx_t    rank_reg;
    logic    beats;

    // A probe that sorts ahead of this cell's sample raises its rank. Equal
    // values are ordered by position so every window gets distinct ranks.
    assign beats = (probe < sample_reg) || ((probe == sample_reg) && probe_before);

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            sample_reg <= shift_in;
        end
        if (ctrl.rank_clr)
        begin
            rank_reg <= '0;
        end
        else if (ctrl.rank_en && beats)
        begin
            rank_reg <= idx_t'(rank_reg + 1'b1);
        end
    end

    assign held = sample_reg;
    assign rank = rank_reg;

endmodule

>>> sv/windowed_median_filter_unit.sv
`timescale 1ns / 1ps

// Streaming centered median filter over signed 16-bit samples. Each output is
// the median of the samples up to half_width either side, with the window cut
// short at both ends of a sequence and the upper median taken for an even
// count; outputs lag the input by half_width samples, and the sample marked
// end_of_seq flushes all owed outputs, the final one marked last. Samples sit
// in a chain of 15 cells; a median is found by broadcasting the window's
// samples one per cycle along the chain while every cell counts how many sort
// ahead of it. The longest item is a flush at half_width 7: eight outputs
// over windows of 15 down to 8 samples. The next sample is taken as soon as
// the last result of an item sits in the output register. half_width resets
// to 1 and should be written only between items.
module windowed_median_filter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  wmf_pkg::half_t      cfg_wr_data,
    wmf_in_if.sink              in_stream,
    wmf_out_if.source           out_stream
);
    import wmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t  state_reg, state_next;
    half_t   half_reg;
    cnt_t    seen_reg, seen_next;
    logic    flush_reg, flush_next;
    idx_t    d_reg, d_next;
    idx_t    lim_reg, lim_next;
    idx_t    lo_reg, lo_next;
    idx_t    hi_reg, hi_next;
    idx_t    k_reg, k_next;
    logic    out_valid_reg, out_valid_next;
    sample_t median_reg, median_next;
    logic    last_reg, last_next;

    cell_ctrl_t ctrl;
    sample_t    held [HIST_DEPTH];
    idx_t       rank [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] earlier;
    logic [HIST_DEPTH-1:0] hit;
    sample_t    probe;
    sample_t    picked;
    idx_t       h;
    cnt_t       seen_new;
    idx_t       lim_new;
    idx_t       top;
    cnt_t       win_cnt;
    idx_t       target;
    win_t       win;
    idx_t       win_d;
    idx_t       win_lim;
    logic       accept;
    logic       load;

    assign h = (int'(half_reg) > MAX_HALF) ? idx_t'(MAX_HALF) : idx_t'(half_reg);

    assign accept = in_stream.valid && (state_reg == ST_IDLE);
    assign in_stream.ready = (state_reg == ST_IDLE);

    assign seen_new = (seen_reg == cnt_t'(HIST_DEPTH)) ? seen_reg : cnt_t'(seen_reg + 1'b1);
    assign lim_new  = idx_t'(seen_new - 1'b1);
    assign top      = (lim_new < h) ? lim_new : h;

    assign probe = held[k_reg];

    // Cell chain: cell 0 takes the new sample, each later cell its neighbor's.
    genvar j;
    generate
        for (j = 0; j < HIST_DEPTH; j++)
        begin : g_cell
            assign earlier[j] = (k_reg < idx_t'(j));

            wmf_cell u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .shift_in     ((j == 0) ? in_stream.sample : held[(j == 0) ? 0 : j - 1]),
                .probe        (probe),
                .probe_before (earlier[j]),
                .held         (held[j]),
                .rank         (rank[j])
            );
        end
    endgenerate

    assign win_cnt = cnt_t'(cnt_t'(hi_reg) - cnt_t'(lo_reg) + cnt_t'(1));
    assign target  = idx_t'(win_cnt >> 1);

    always_comb
    begin
        picked = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hit[i] = (idx_t'(i) >= lo_reg) && (idx_t'(i) <= hi_reg) && (rank[i] == target);
            if (hit[i])
            begin
                picked = picked | held[i];
            end
        end
    end

    assign load = (state_reg == ST_PUSH) && (!out_valid_reg || out_stream.ready);

    // The window for the next output is worked out from the new offset.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            win_d   = in_stream.end_of_seq ? top : h;
            win_lim = lim_new;
        end
        else
        begin
            win_d   = idx_t'(d_reg - 1'b1);
            win_lim = lim_reg;
        end
    end

    assign win = win_bounds(win_d, h, win_lim);

    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        flush_next     = flush_reg;
        d_next         = d_reg;
        lim_next       = lim_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        median_next    = median_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_stream.ready;
        ctrl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.shift_en = 1'b1;
                    ctrl.rank_clr = 1'b1;
                    lim_next      = lim_new;
                    d_next        = win_d;
                    lo_next       = win.lo;
                    hi_next       = win.hi;
                    k_next        = win.lo;
                    if (in_stream.end_of_seq)
                    begin
                        flush_next = 1'b1;
                        seen_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        flush_next = 1'b0;
                        seen_next  = seen_new;
                        if (seen_new > cnt_t'(h))
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                ctrl.rank_en = 1'b1;
                if (k_reg == hi_reg)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    k_next = idx_t'(k_reg + 1'b1);
                end
            end

            ST_PUSH:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    median_next    = picked;
                    last_next      = flush_reg && (d_reg == '0);
                    if (flush_reg && (d_reg != '0))
                    begin
                        ctrl.rank_clr = 1'b1;
                        d_next        = win_d;
                        lo_next       = win.lo;
                        hi_next       = win.hi;
                        k_next        = win.lo;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            half_reg      <= half_t'(1);
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                half_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        flush_reg  <= flush_next;
        d_reg      <= d_next;
        lim_reg    <= lim_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        k_reg      <= k_next;
        median_reg <= median_next;
        last_reg   <= last_next;
    end

    assign out_stream.valid  = out_valid_reg;
    assign out_stream.median = median_reg;
    assign out_stream.last   = last_reg;

    // Once the scan is done, exactly one cell of the window holds the median rank.
    a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> $onehot(hit))
        else $error("median rank not unique in window");

    // The scan index stays inside the window.
    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((k_reg >= lo_reg) && (k_reg <= hi_reg)))
        else $error("scan index outside window");

    // The final output of a sequence leaves the block idle with a fresh count.
    a_last_ends_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (load && flush_reg && (d_reg == '0)) |=> ((state_reg == ST_IDLE) && (seen_reg == '0)))
        else $error("sequence not closed after last output");

endmodule
